### design/tbfd_pkg.sv
package tbfd_pkg;

  localparam int FILE_BYTES  = 202752;
  localparam int DATA_BYTES  = 202748;
  localparam int BLOCK_COUNT = 28;
  localparam int TAG_BYTES   = 5;

  localparam int POS_W   = 18;
  localparam int SLOT_W  = 5;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 23;
  localparam int SUM_W   = 32;
  localparam int STAT_W  = 3;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = 3;
  localparam int OUTQ_CW    = 4;

  localparam logic CMD_LAYOUT = 1'b0;
  localparam logic CMD_BYTE   = 1'b1;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_SIZE     = 3'd1;
  localparam logic [STAT_W-1:0] ST_CHECKSUM = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_TAG      = 3'd4;

  typedef struct packed {
    logic              cmd;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  length;
    logic [BYTE_W-1:0] fbyte;
    logic              eof;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic              last;
    logic [SLOT_W-1:0] blk;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  offset;
    logic [STAT_W-1:0] status;
  } result_t;

  // A status result alone goes in the first slot; both slots imply the first.
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  typedef struct packed {
    logic [POS_W-1:0]   cur_size;
    logic [TOTAL_W-1:0] total;
  } layout_view_t;

  function automatic logic [BYTE_W-1:0] tag_char(input logic [2:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      3'd0: c = 8'h42;
      3'd1: c = 8'h4C;
      3'd2: c = 8'h4F;
      3'd3: c = 8'h43;
      3'd4: c = 8'h4B;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/tagged_block_file_deframer_core.sv
// Channel   Dir  tuser    tlast        tdata (lowest bit up)
// s_axis    in   command  end_of_file  table_slot, payload_length, file_byte
// m_axis    out  kind     last         block_number, payload_value,
//                                      offset_in_block, status
//
// One item is accepted per cycle while s_tready is high. An item is held in
// the input register, where the parser and the layout table update, and its
// results enter an eight-entry output queue, from which m_axis is driven; the
// first result is valid on m_axis once the queue has registered it. The queue
// sets the rate: s_tready is high while it holds four results or fewer, so a
// stalled output fills it and then backpressures the input. Synchronous reset
// clears the layout table, the per-file state and the queue.
module tagged_block_file_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // table_slot[4:0], payload_length[22:5], file_byte[30:23]
  input  logic        s_tuser,  // command
  input  logic        s_tlast,  // end_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // block_number[4:0], payload_value[12:5],
                                // offset_in_block[30:13], status[33:31]
  output logic        m_tuser,  // kind
  output logic        m_tlast   // last
);

  logic                          in_valid;
  tbfd_pkg::item_t               in_item;
  tbfd_pkg::layout_view_t        layout;
  logic [tbfd_pkg::SLOT_W-1:0]   cursor;
  tbfd_pkg::push_t               push;
  logic [tbfd_pkg::POS_W-1:0]    file_pos;
  tbfd_pkg::result_t             out_res;
  logic [tbfd_pkg::OUTQ_CW-1:0]  level;

  assign s_tready = level <= tbfd_pkg::OUTQ_CW'(tbfd_pkg::OUTQ_DEPTH - 4);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= s_tvalid && s_tready;
    end
    if (s_tvalid && s_tready) begin
      in_item.cmd    <= s_tuser;
      in_item.slot   <= s_tdata[4:0];
      in_item.length <= s_tdata[22:5];
      in_item.fbyte  <= s_tdata[30:23];
      in_item.eof    <= s_tlast;
    end
  end

  tbfd_layout u_layout (
    .clk    (clk),
    .rst    (rst),
    .wr     (in_valid && in_item.cmd == tbfd_pkg::CMD_LAYOUT),
    .slot   (in_item.slot),
    .length (in_item.length),
    .cursor (cursor),
    .view   (layout)
  );

  tbfd_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .item     (in_item),
    .layout   (layout),
    .cursor   (cursor),
    .push     (push),
    .file_pos (file_pos)
  );

  tbfd_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .level     (level)
  );

  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;
  assign m_tdata = {6'b0, out_res.status, out_res.offset, out_res.value, out_res.blk};

  // The queue always has room for both results of the item being parsed.
  a_room: assert property (@(posedge clk) disable iff (rst)
    in_valid |-> level <= tbfd_pkg::OUTQ_CW'(tbfd_pkg::OUTQ_DEPTH - 2))
    else $error("output queue lacks room for a parsed item");

  // The final byte of a file leaves the parser at the start of the next file.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_item.cmd == tbfd_pkg::CMD_BYTE && in_item.eof) |=> file_pos == '0)
    else $error("file position not cleared after end of file");

  // Payload results never carry a status or close a file.
  a_payload: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == tbfd_pkg::KIND_PAYLOAD) |->
      (!m_tlast && m_tdata[33:31] == tbfd_pkg::ST_OK))
    else $error("payload result carries status");

endmodule

### design/tbfd_layout.sv
module tbfd_layout (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr,
  input  logic [tbfd_pkg::SLOT_W-1:0]   slot,
  input  logic [tbfd_pkg::POS_W-1:0]    length,
  input  logic [tbfd_pkg::SLOT_W-1:0]   cursor,
  output tbfd_pkg::layout_view_t        view
);

  logic [tbfd_pkg::POS_W-1:0]   sizes [tbfd_pkg::BLOCK_COUNT];
  logic [tbfd_pkg::TOTAL_W-1:0] total;
  logic                         slot_ok;

  assign slot_ok = slot < tbfd_pkg::SLOT_W'(tbfd_pkg::BLOCK_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < tbfd_pkg::BLOCK_COUNT; i++) begin
        sizes[i] <= '0;
      end
      total <= '0;
    end else if (wr && slot_ok) begin
      total       <= total - tbfd_pkg::TOTAL_W'(sizes[slot])
                     + tbfd_pkg::TOTAL_W'(length);
      sizes[slot] <= length;
    end
  end

  always_comb begin
    view.total = total;
    if (cursor < tbfd_pkg::SLOT_W'(tbfd_pkg::BLOCK_COUNT)) begin
      view.cur_size = sizes[cursor];
    end else begin
      view.cur_size = '0;
    end
  end

endmodule

### design/tbfd_parse.sv
module tbfd_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  tbfd_pkg::item_t              item,
  input  tbfd_pkg::layout_view_t       layout,
  output logic [tbfd_pkg::SLOT_W-1:0]  cursor,
  output tbfd_pkg::push_t              push,
  output logic [tbfd_pkg::POS_W-1:0]   file_pos
);

  typedef enum logic [1:0] {RG_TAG, RG_PAYLOAD, RG_PAD} region_t;

  localparam logic [tbfd_pkg::POS_W-1:0] FILE_B = tbfd_pkg::POS_W'(tbfd_pkg::FILE_BYTES);
  localparam logic [tbfd_pkg::POS_W-1:0] DATA_B = tbfd_pkg::POS_W'(tbfd_pkg::DATA_BYTES);
  localparam logic [tbfd_pkg::POS_W-1:0] SUM_END =
    tbfd_pkg::POS_W'(tbfd_pkg::DATA_BYTES + 4);
  localparam logic [tbfd_pkg::POS_W-1:0] LAST_B =
    tbfd_pkg::POS_W'(tbfd_pkg::FILE_BYTES - 1);
  localparam logic [tbfd_pkg::POS_W-1:0] TAG_B = tbfd_pkg::POS_W'(tbfd_pkg::TAG_BYTES);
  localparam logic [tbfd_pkg::TOTAL_W:0] TAG_AREA =
    (tbfd_pkg::TOTAL_W+1)'(tbfd_pkg::BLOCK_COUNT * tbfd_pkg::TAG_BYTES);
  localparam logic [tbfd_pkg::TOTAL_W:0] DATA_WIDE =
    (tbfd_pkg::TOTAL_W+1)'(tbfd_pkg::DATA_BYTES);

  logic [tbfd_pkg::POS_W-1:0]  bytes_seen, bytes_seen_next;
  logic [tbfd_pkg::SUM_W-1:0]  running_sum, running_sum_next;
  logic [tbfd_pkg::SUM_W-1:0]  stored_sum, stored_sum_next;
  logic [tbfd_pkg::SLOT_W-1:0] block_cursor, block_cursor_next;
  region_t                     region, region_next;
  logic [tbfd_pkg::POS_W-1:0]  region_pos, region_pos_next;
  logic                        tag_bad, tag_bad_next;
  logic                        pad_bad, pad_bad_next;
  logic                        length_bad, length_bad_next;

  logic [tbfd_pkg::POS_W-1:0]   sum_ofs;
  logic [tbfd_pkg::TOTAL_W:0]   need;
  logic [tbfd_pkg::STAT_W-1:0]  st;
  tbfd_pkg::result_t            pay_res;
  tbfd_pkg::result_t            st_res;
  logic                         pay_v;

  assign cursor   = block_cursor;
  assign file_pos = bytes_seen;
  assign sum_ofs  = bytes_seen - DATA_B;
  assign need     = {1'b0, layout.total} + TAG_AREA;

  always_comb begin
    bytes_seen_next   = bytes_seen;
    running_sum_next  = running_sum;
    stored_sum_next   = stored_sum;
    block_cursor_next = block_cursor;
    region_next       = region;
    region_pos_next   = region_pos;
    tag_bad_next      = tag_bad;
    pad_bad_next      = pad_bad;
    length_bad_next   = length_bad;
    pay_v             = 1'b0;
    pay_res           = '0;
    st_res            = '0;
    st                = tbfd_pkg::ST_OK;
    push              = '0;

    if (in_valid && item.cmd == tbfd_pkg::CMD_BYTE) begin
      if (bytes_seen >= FILE_B) begin
        length_bad_next = 1'b1;
      end

      if (bytes_seen < DATA_B) begin
        running_sum_next = running_sum + tbfd_pkg::SUM_W'(item.fbyte);
        // A finished payload hands over to the next tag, or to padding after
        // the last block, before this byte is looked at.
        if (region == RG_PAYLOAD && region_pos >= layout.cur_size) begin
          block_cursor_next = block_cursor + 1'b1;
          region_pos_next   = '0;
          region_next = (block_cursor_next >= tbfd_pkg::SLOT_W'(tbfd_pkg::BLOCK_COUNT))
                        ? RG_PAD : RG_TAG;
        end
        case (region_next)
          RG_TAG: begin
            if (item.fbyte != tbfd_pkg::tag_char(region_pos_next[2:0])) begin
              tag_bad_next = 1'b1;
            end
            region_pos_next = region_pos_next + 1'b1;
            if (region_pos_next >= TAG_B) begin
              region_pos_next = '0;
              region_next     = RG_PAYLOAD;
            end
          end
          RG_PAYLOAD: begin
            pay_v          = 1'b1;
            pay_res.kind   = tbfd_pkg::KIND_PAYLOAD;
            pay_res.blk    = block_cursor_next;
            pay_res.value  = item.fbyte;
            pay_res.offset = region_pos_next;
            region_pos_next = region_pos_next + 1'b1;
          end
          default: begin
            if (item.fbyte != '0) begin
              pad_bad_next = 1'b1;
            end
          end
        endcase
      end else if (bytes_seen < SUM_END) begin
        stored_sum_next[{sum_ofs[1:0], 3'b000} +: 8] = item.fbyte;
      end

      if (bytes_seen < tbfd_pkg::POS_MAX) begin
        bytes_seen_next = bytes_seen + 1'b1;
      end

      push.v0 = pay_v;
      push.r0 = pay_res;

      if (item.eof) begin
        if (length_bad_next || bytes_seen != LAST_B) begin
          st = tbfd_pkg::ST_SIZE;
        end else if (running_sum_next != stored_sum_next) begin
          st = tbfd_pkg::ST_CHECKSUM;
        end else if (need > DATA_WIDE) begin
          st = tbfd_pkg::ST_OVERFLOW;
        end else if (tag_bad_next) begin
          st = tbfd_pkg::ST_TAG;
        end else if (pad_bad_next) begin
          st = tbfd_pkg::ST_SIZE;
        end
        st_res.kind   = tbfd_pkg::KIND_STATUS;
        st_res.last   = 1'b1;
        st_res.status = st;
        if (pay_v) begin
          push.v1 = 1'b1;
          push.r1 = st_res;
        end else begin
          push.v0 = 1'b1;
          push.r0 = st_res;
        end
        bytes_seen_next   = '0;
        running_sum_next  = '0;
        stored_sum_next   = '0;
        block_cursor_next = '0;
        region_next       = RG_TAG;
        region_pos_next   = '0;
        tag_bad_next      = 1'b0;
        pad_bad_next      = 1'b0;
        length_bad_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      running_sum  <= '0;
      stored_sum   <= '0;
      block_cursor <= '0;
      region       <= RG_TAG;
      region_pos   <= '0;
      tag_bad      <= 1'b0;
      pad_bad      <= 1'b0;
      length_bad   <= 1'b0;
    end else begin
      bytes_seen   <= bytes_seen_next;
      running_sum  <= running_sum_next;
      stored_sum   <= stored_sum_next;
      block_cursor <= block_cursor_next;
      region       <= region_next;
      region_pos   <= region_pos_next;
      tag_bad      <= tag_bad_next;
      pad_bad      <= pad_bad_next;
      length_bad   <= length_bad_next;
    end
  end

endmodule

### design/tbfd_outq.sv
module tbfd_outq (
  input  logic                         clk,
  input  logic                         rst,
  input  tbfd_pkg::push_t              push,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tbfd_pkg::result_t            out_res,
  output logic [tbfd_pkg::OUTQ_CW-1:0] level
);

  tbfd_pkg::result_t               slots [tbfd_pkg::OUTQ_DEPTH];
  logic [tbfd_pkg::OUTQ_AW-1:0]    wr_ptr;
  logic [tbfd_pkg::OUTQ_AW-1:0]    rd_ptr;
  logic [tbfd_pkg::OUTQ_AW-1:0]    wr_ptr_1;
  logic [tbfd_pkg::OUTQ_CW-1:0]    n_push;
  logic                            pop;

  assign out_valid = level != '0;
  assign out_res   = slots[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign wr_ptr_1  = wr_ptr + 1'b1;
  assign n_push    = tbfd_pkg::OUTQ_CW'(push.v0) + tbfd_pkg::OUTQ_CW'(push.v1);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.v1) begin
      slots[wr_ptr_1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tbfd_pkg::OUTQ_AW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      level <= level + n_push - tbfd_pkg::OUTQ_CW'(pop);
    end
  end

endmodule

### bench/tagged_block_file_deframer_checker.sv
`timescale 1ns / 1ps

module tagged_block_file_deframer_checker
  import tbfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,  // table_slot[4:0], payload_length[22:5], file_byte[30:23]
  input  logic        s_tuser,  // command
  input  logic        s_tlast,  // end_of_file
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,  // block_number[4:0], payload_value[12:5],
                                // offset_in_block[30:13], status[33:31]
  input  logic        m_tuser,  // kind
  input  logic        m_tlast,  // last
  output int          mismatch_count,
  output int          results_owed
);

  typedef enum logic [1:0] {AREA_TAG, AREA_PAYLOAD, AREA_PAD} area_t;

  localparam logic [39:0] TAG_TEXT = "BLOCK";

  logic [POS_W-1:0]   blk_len [BLOCK_COUNT];
  logic [TOTAL_W-1:0] layout_sum;
  logic [POS_W-1:0]   byte_idx;
  logic [SUM_W-1:0]   data_sum;
  logic [SUM_W-1:0]   file_sum;
  logic [SLOT_W-1:0]  cur_blk;
  area_t              area;
  logic [POS_W-1:0]   area_pos;
  logic               tag_err;
  logic               pad_err;
  logic               len_err;

  result_t pending_results[$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
  end

  task automatic clear_file();
    byte_idx = '0;
    data_sum = '0;
    file_sum = '0;
    cur_blk  = '0;
    area     = AREA_TAG;
    area_pos = '0;
    tag_err  = 1'b0;
    pad_err  = 1'b0;
    len_err  = 1'b0;
  endtask

  task automatic deframe_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                              input logic [POS_W-1:0] len, input logic [BYTE_W-1:0] fbyte,
                              input logic eof);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] active_len;
    logic [BYTE_W-1:0] want;
    logic [STAT_W-1:0] st;
    result_t r;
    int k;
    p = byte_idx;
    if (cmd == CMD_LAYOUT) begin
      // Writes to slots beyond the table are dropped; end_of_file means nothing here.
      if (slot < BLOCK_COUNT) begin
        layout_sum = layout_sum - TOTAL_W'(blk_len[slot]) + TOTAL_W'(len);
        blk_len[slot] = len;
      end
    end else begin
      if (p >= FILE_BYTES) len_err = 1'b1;
      if (p < DATA_BYTES) begin
        data_sum = data_sum + SUM_W'(fbyte);
        active_len = (cur_blk < BLOCK_COUNT) ? blk_len[cur_blk] : '0;
        // A payload can end late if its size shrank under it mid-file.
        if (area == AREA_PAYLOAD && area_pos >= active_len) begin
          cur_blk  = cur_blk + 1'b1;
          area_pos = '0;
          area     = (cur_blk >= BLOCK_COUNT) ? AREA_PAD : AREA_TAG;
        end
        if (area == AREA_TAG) begin
          k = 4 - int'(area_pos);
          want = (area_pos < 5) ? TAG_TEXT[8*k +: 8] : 8'h00;
          if (fbyte != want) tag_err = 1'b1;
          area_pos = area_pos + 1'b1;
          if (area_pos >= TAG_BYTES) begin
            area_pos = '0;
            area     = AREA_PAYLOAD;
          end
        end else if (area == AREA_PAYLOAD) begin
          r        = '0;
          r.kind   = KIND_PAYLOAD;
          r.blk    = cur_blk;
          r.value  = fbyte;
          r.offset = area_pos;
          r.status = ST_OK;
          pending_results.push_back(r);
          area_pos = area_pos + 1'b1;
        end else if (fbyte != 8'h00) begin
          pad_err = 1'b1;
        end
      end else if (int'(p) - DATA_BYTES < 4) begin
        k = int'(p) - DATA_BYTES;
        file_sum[8*k +: 8] = fbyte;
      end
      if (byte_idx < POS_MAX) byte_idx = byte_idx + 1'b1;
      if (eof) begin
        if (len_err || int'(p) != FILE_BYTES - 1) st = ST_SIZE;
        else if (data_sum != file_sum) st = ST_CHECKSUM;
        else if (int'(layout_sum) + BLOCK_COUNT * TAG_BYTES > DATA_BYTES) st = ST_OVERFLOW;
        else if (tag_err) st = ST_TAG;
        else if (pad_err) st = ST_SIZE;
        else st = ST_OK;
        r        = '0;
        r.kind   = KIND_STATUS;
        r.last   = 1'b1;
        r.status = st;
        pending_results.push_back(r);
        clear_file();
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t oldest;
    if (rst) begin
      for (int i = 0; i < BLOCK_COUNT; i++) blk_len[i] = '0;
      layout_sum = '0;
      clear_file();
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $error("result with none expected: kind %0d, tdata %h", m_tuser, m_tdata);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("kind", int'(oldest.kind), int'(m_tuser));
          check_field("block_number", int'(oldest.blk), int'(m_tdata[4:0]));
          check_field("payload_value", int'(oldest.value), int'(m_tdata[12:5]));
          check_field("offset_in_block", int'(oldest.offset), int'(m_tdata[30:13]));
          check_field("status", int'(oldest.status), int'(m_tdata[33:31]));
          check_field("last", int'(oldest.last), int'(m_tlast));
        end
      end
      if (s_tvalid && s_tready)
        deframe_item(s_tuser, s_tdata[4:0], s_tdata[22:5], s_tdata[30:23], s_tlast);
    end
    results_owed <= pending_results.size();
  end

endmodule

### bench/tagged_block_file_deframer_core_tb.sv
`timescale 1ns / 1ps

module tagged_block_file_deframer_core_tb;
  import tbfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 210;
  localparam logic [39:0] TAG_TEXT = "BLOCK";

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  int mismatch_count;
  int results_owed;
  int cycle_count;
  int item_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  // Sender's own view of the layout, used to shape well-formed files.
  int lay_size [BLOCK_COUNT];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  tagged_block_file_deframer_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  tagged_block_file_deframer_checker watch (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .s_tlast        (s_tlast),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .m_tlast        (m_tlast),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  task automatic push_item(input logic cmd, input logic [SLOT_W-1:0] slot,
                           input logic [POS_W-1:0] len, input logic [BYTE_W-1:0] fbyte,
                           input logic eof);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tlast  <= eof;
    s_tdata  <= {1'b0, fbyte, len, slot};
    do @(posedge clk); while (!s_tready);
    item_count++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic lay_write(input logic [SLOT_W-1:0] slot, input logic [POS_W-1:0] len,
                           input logic eof);
    push_item(CMD_LAYOUT, slot, len, BYTE_W'($urandom), eof);
    if (slot < BLOCK_COUNT) lay_size[slot] = int'(len);
  endtask

  task automatic file_byte_item(input logic [BYTE_W-1:0] b, input logic eof);
    push_item(CMD_BYTE, SLOT_W'($urandom), POS_W'($urandom), b, eof);
  endtask

  task automatic random_layout();
    logic [POS_W-1:0] len;
    len = POS_W'(($urandom_range(4) == 0) ? $urandom_range(0, 262143)
                                          : $urandom_range(0, 6));
    lay_write(SLOT_W'($urandom_range(0, 31)), len, 1'($urandom_range(1)));
  endtask

  task automatic put_tag();
    for (int i = 0; i < TAG_BYTES; i++) file_byte_item(TAG_TEXT[8*(4-i) +: 8], 1'b0);
  endtask

  // Streams one file laid out after the current table, with its own checksum word.
  // Noise and the spoil flags break the tag, padding or checksum on purpose.
  task automatic send_file(input int flen, input int noise_permil, input int relayout_pct,
                           input bit spoil_tag, input bit spoil_pad, input bit spoil_sum);
    int blk;
    int pos;
    bit in_tag;
    logic [SUM_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    blk = 0;
    pos = 0;
    in_tag = 1'b1;
    sum = '0;
    for (int p = 0; p < flen; p++) begin
      if ($urandom_range(99) < relayout_pct) random_layout();
      if (p < DATA_BYTES) begin
        while (blk < BLOCK_COUNT && !in_tag && pos >= lay_size[blk]) begin
          blk++;
          pos = 0;
          in_tag = 1'b1;
        end
        if (blk >= BLOCK_COUNT) begin
          b = (spoil_pad && p == DATA_BYTES - 1) ? 8'h01 : 8'h00;
        end else if (in_tag) begin
          b = TAG_TEXT[8*(4-pos) +: 8];
          if (spoil_tag && blk == BLOCK_COUNT - 1 && pos == 2) b = 8'h3F;
          pos++;
          if (pos == TAG_BYTES) begin
            pos = 0;
            in_tag = 1'b0;
          end
        end else begin
          b = BYTE_W'($urandom);
          pos++;
        end
        if ($urandom_range(999) < noise_permil) b = BYTE_W'($urandom);
        sum = sum + SUM_W'(b);
      end else if (p < DATA_BYTES + 4) begin
        b = sum[8*(p-DATA_BYTES) +: 8];
        if (spoil_sum && p == DATA_BYTES) b = b ^ 8'h01;
      end else begin
        b = BYTE_W'($urandom);
      end
      file_byte_item(b, p == flen - 1);
    end
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct);
    int first;
    int flen;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    first = item_count;
    while (item_count - first < PHASE_ITEMS) begin
      if ($urandom_range(1)) repeat ($urandom_range(1, 3)) random_layout();
      flen = ($urandom_range(7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 60);
      send_file(flen, 20, 4, 1'b0, 1'b0, 1'b0);
    end
    wait_results();
  endtask

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < BLOCK_COUNT; i++) lay_size[i] = 0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= CMD_LAYOUT;
    s_tlast  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Table extremes, ignored slots, and end_of_file on a layout write.
    lay_write(5'd0, 18'd2, 1'b0);
    lay_write(5'd1, 18'd0, 1'b0);
    lay_write(SLOT_W'(BLOCK_COUNT - 1), 18'h3FFFF, 1'b0);
    lay_write(5'd31, 18'h3FFFF, 1'b1);
    lay_write(SLOT_W'(BLOCK_COUNT), 18'd1, 1'b0);
    // Payload byte extremes, an empty block, then a broken tag in a short file.
    put_tag();
    file_byte_item(8'h00, 1'b0);
    file_byte_item(8'hFF, 1'b0);
    put_tag();
    file_byte_item("B", 1'b0);
    file_byte_item(8'h00, 1'b1);
    // A file of a single byte.
    file_byte_item(8'hFF, 1'b1);
    // Shrinking the current payload mid-file ends it before the next byte.
    put_tag();
    file_byte_item(8'h5A, 1'b0);
    lay_write(5'd0, 18'd0, 1'b0);
    file_byte_item("B", 1'b1);
    wait_results();

    // Long output stall while the sender keeps going, so the input backs up.
    lay_write(5'd0, 18'd50, 1'b0);
    hold_req = 1'b1;
    send_file(80, 0, 0, 1'b0, 1'b0, 1'b0);
    wait_results();

    run_phase(0, 0);
    run_phase(47, 0);
    run_phase(0, 47);
    run_phase(36, 36);
    repeat (16) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
design/tbfd_pkg.sv
design/tbfd_layout.sv
design/tbfd_parse.sv
design/tbfd_outq.sv
design/tagged_block_file_deframer_core.sv
bench/tagged_block_file_deframer_checker.sv
bench/tagged_block_file_deframer_core_tb.sv
